/* src/wts_pkg.sv */
// shared types, constants and helpers of the waypoint time stamper
// no dependencies
`default_nettype none

package wts_pkg;

  typedef struct packed {
    logic signed [31:0] way_x_mm;
    logic signed [31:0] way_y_mm;
    logic [15:0]        way_speed;
    logic               path_end;
  } way_t;

  typedef struct packed {
    logic signed [31:0] point_x_mm;
    logic signed [31:0] point_y_mm;
    logic [47:0]        point_time_ns;
    logic               zero_speed;
    logic               last_point;
  } point_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SPAN   = 2'd0;
  localparam logic [1:0] CFG_POSE_X = 2'd1;
  localparam logic [1:0] CFG_POSE_Y = 2'd2;

  // path phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_PATH  = 2'd1;
  localparam logic [1:0] PH_CUT   = 2'd2;

  localparam logic [39:0] SPAN_RESET = 40'd6000000000;
  localparam logic [47:0] MAX48      = {48{1'b1}};
  localparam logic [31:0] NEAR_MM    = 32'd100;

  // 10^18 = (10^9)^2, squared scale to nanomillimeters, split into two multiplier operands
  localparam logic [59:0] NANO_SQ = 60'd1000000000000000000;
  localparam logic [31:0] NANO_LO = NANO_SQ[31:0];
  localparam logic [31:0] NANO_HI = {4'b0, NANO_SQ[59:32]};

  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

`default_nettype wire

/* src/waypoint_time_stamper.sv */
// Waypoint time stamper: turns a stream of waypoints into timed trajectory
// points. Each request carries one waypoint; it gives zero, one or two points.
// One request is worked at a time and in_stall stays high until its points
// are in the output register. Work per request: a waypoint inside a path
// takes one distance pass (two squares, six partial products of the
// nanomillimeter scaling on the shared 32x32 multiplier and 63 square-root
// steps), then two divisions for segment time and travel time. The first
// waypoint of a path takes one distance and one division when it is far
// from the pose and neither when near. A waypoint after the cut is
// discarded while the block stays idle.
// The output register lets a finished point wait while the next request is
// taken. Configuration is written through cfg_valid/cfg_index/cfg_data,
// always ready, and should only change while the block is idle.
// depends on wts_pkg, wts_dist, wts_div
`default_nettype none

module waypoint_time_stamper (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  wts_pkg::way_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output wts_pkg::point_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [39:0]    cfg_data
);
  import wts_pkg::*;

  // sequencer states
  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,  // waiting for a request
    T_POSE = 6'b000010,  // pose point waiting for the output register
    T_DIST = 6'b000100,  // distance unit running
    T_DIV1 = 6'b001000,  // segment time for the horizon
    T_DIV2 = 6'b010000,  // travel time of the point
    T_EMIT = 6'b100000   // waypoint point waiting for the output register
  } tstate_t;

  tstate_t state;

  // configuration
  logic [39:0]        span_ns;
  logic signed [31:0] pose_x, pose_y;

  // path state
  logic signed [31:0] prev_way_x, prev_way_y;
  logic [15:0]        prev_speed;
  logic [47:0]        horizon_time, prev_point_time;
  logic [1:0]         path_phase;

  // current request
  logic signed [31:0] wx, wy;
  logic [15:0]        v;
  logic               endf;
  logic               in_path;
  logic [31:0]        mag_x, mag_y;
  logic [62:0]        dist_r;
  logic [63:0]        div_num;
  logic [16:0]        div_den;
  logic               dist_go, div_go;
  logic [47:0]        pt_time;
  logic               pt_zero;
  logic               cut;

  // unit outputs
  logic               dist_done, div_done;
  logic [62:0]        dist_root;
  logic [47:0]        div_q;

  logic               accept, slot_free, far, out_load;
  logic [31:0]        path_mx, path_my, pose_mx, pose_my;
  logic [16:0]        v_sum;
  logic [47:0]        horizon_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  // a point goes into the output register this cycle
  assign out_load  = slot_free && ((state == T_POSE) || (state == T_EMIT));

  // offsets from the previous waypoint and from the pose
  assign path_mx = mag33({in_data.way_x_mm[31], in_data.way_x_mm} - {prev_way_x[31], prev_way_x});
  assign path_my = mag33({in_data.way_y_mm[31], in_data.way_y_mm} - {prev_way_y[31], prev_way_y});
  assign pose_mx = mag33({pose_x[31], pose_x} - {in_data.way_x_mm[31], in_data.way_x_mm});
  assign pose_my = mag33({pose_y[31], pose_y} - {in_data.way_y_mm[31], in_data.way_y_mm});
  assign far     = (pose_mx > NEAR_MM) || (pose_my > NEAR_MM);

  // mean-speed divisor: 2r / (v_prev + v_cur)
  assign v_sum       = {1'b0, v} + {1'b0, prev_speed};
  assign horizon_new = sat_add48(horizon_time, div_q);

  wts_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .start (dist_go),
    .mag_x (mag_x),
    .mag_y (mag_y),
    .done  (dist_done),
    .root  (dist_root)
  );

  wts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      out_valid       <= 1'b0;
      span_ns         <= SPAN_RESET;
      pose_x          <= '0;
      pose_y          <= '0;
      prev_way_x      <= '0;
      prev_way_y      <= '0;
      prev_speed      <= '0;
      horizon_time    <= '0;
      prev_point_time <= '0;
      path_phase      <= PH_FIRST;
      dist_go         <= 1'b0;
      div_go          <= 1'b0;
    end else begin
      // distance starts for a path waypoint or once the pose point is out
      dist_go <= ((state == T_IDLE) && accept && (path_phase == PH_PATH)) ||
                 ((state == T_POSE) && slot_free);
      // a division starts after the distance and after the segment time
      div_go  <= ((state == T_DIST) && dist_done) || ((state == T_DIV1) && div_done);

      if (cfg_valid) begin
        case (cfg_index)
          CFG_SPAN:   span_ns <= cfg_data;
          CFG_POSE_X: pose_x  <= cfg_data[31:0];
          CFG_POSE_Y: pose_y  <= cfg_data[31:0];
          default:    ;
        endcase
      end

      // output register loads a new point or drains when taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        T_IDLE: begin
          if (accept) begin
            wx   <= in_data.way_x_mm;
            wy   <= in_data.way_y_mm;
            v    <= in_data.way_speed;
            endf <= in_data.path_end;
            cut  <= 1'b0;
            if (path_phase == PH_CUT) begin
              // discarding after the cut until the path ends
              if (in_data.path_end) begin
                path_phase <= PH_FIRST;
              end
            end else if (path_phase == PH_PATH) begin
              in_path <= 1'b1;
              mag_x   <= path_mx;
              mag_y   <= path_my;
              state   <= T_DIST;
            end else begin
              // first waypoint: pose point first if the pose is far off
              in_path <= 1'b0;
              if (far) begin
                mag_x <= pose_mx;
                mag_y <= pose_my;
                state <= T_POSE;
              end else begin
                pt_time <= '0;
                pt_zero <= 1'b0;
                state   <= T_EMIT;
              end
            end
          end
        end
        T_POSE: begin
          if (slot_free) begin
            out_data.point_x_mm    <= pose_x;
            out_data.point_y_mm    <= pose_y;
            out_data.point_time_ns <= '0;
            out_data.zero_speed    <= 1'b0;
            out_data.last_point    <= 1'b0;
            state                  <= T_DIST;
          end
        end
        T_DIST: begin
          if (dist_done) begin
            dist_r <= dist_root;
            if (in_path) begin
              div_num <= {dist_root, 1'b0};
              div_den <= v_sum;
              state   <= T_DIV1;
            end else begin
              div_num <= {1'b0, dist_root};
              div_den <= {1'b0, v};
              state   <= T_DIV2;
            end
          end
        end
        T_DIV1: begin
          if (div_done) begin
            // zero mean speed saturates the segment and cuts here
            horizon_time <= horizon_new;
            cut          <= horizon_new >= {8'b0, span_ns};
            div_num      <= {1'b0, dist_r};
            div_den      <= {1'b0, prev_speed};
            state        <= T_DIV2;
          end
        end
        T_DIV2: begin
          if (div_done) begin
            pt_time <= in_path ? sat_add48(prev_point_time, div_q) : div_q;
            pt_zero <= (div_den == 17'd0);
            state   <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (slot_free) begin
            out_data.point_x_mm    <= wx;
            out_data.point_y_mm    <= wy;
            out_data.point_time_ns <= pt_time;
            out_data.zero_speed    <= pt_zero;
            out_data.last_point    <= endf || cut;
            prev_way_x             <= wx;
            prev_way_y             <= wy;
            prev_speed             <= v;
            prev_point_time        <= pt_time;
            if (!in_path) begin
              horizon_time <= '0;
            end
            if (endf) begin
              path_phase <= PH_FIRST;
            end else if (cut) begin
              path_phase <= PH_CUT;
            end else begin
              path_phase <= PH_PATH;
            end
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/wts_dist.sv */
// distance unit: squares, scaling by 10^18 to nanomillimeters and bit-serial square root
// one shared 32x32 multiplier; uses wts_pkg
`default_nettype none

module wts_dist (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] mag_x,
  input  logic [31:0] mag_y,
  output logic        done,
  output logic [62:0] root
);
  import wts_pkg::*;

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_SQX  = 6'b000010,
    D_SQY  = 6'b000100,
    D_SUM  = 6'b001000,
    D_MAC  = 6'b010000,
    D_ROOT = 6'b100000
  } dstate_t;

  localparam logic [2:0] MAC_STEPS = 3'd6;
  localparam logic [5:0] ROOT_LAST = 6'd62;

  dstate_t      state;
  logic [31:0]  ux, uy;
  logic [63:0]  prod;
  logic [1:0]   prod_sh;
  logic [64:0]  d2;
  logic [125:0] acc;
  logic [2:0]   idx;
  logic [5:0]   cnt;
  logic [67:0]  rem;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod_next;
  logic [125:0] acc_add;
  logic [67:0]  rem_sh, trial;
  logic         ge;

  always_comb begin
    case (state)
      D_SQX: begin
        mul_a = ux;
        mul_b = ux;
      end
      D_SQY: begin
        mul_a = uy;
        mul_b = uy;
      end
      default: begin
        case (idx[2:1])
          2'd0:    mul_a = d2[31:0];
          2'd1:    mul_a = d2[63:32];
          default: mul_a = {31'b0, d2[64]};
        endcase
        mul_b = idx[0] ? NANO_HI : NANO_LO;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign acc_add   = 126'(prod) << {prod_sh, 5'b0};
  assign rem_sh    = {rem[65:0], acc[125:124]};
  assign trial     = {3'b0, root, 2'b01};
  assign ge        = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_ROOT) && (cnt == ROOT_LAST);
      case (state)
        D_IDLE: begin
          if (start) begin
            ux    <= mag_x;
            uy    <= mag_y;
            state <= D_SQX;
          end
        end
        D_SQX: begin
          prod  <= prod_next;
          state <= D_SQY;
        end
        D_SQY: begin
          d2    <= {1'b0, prod};
          prod  <= prod_next;
          state <= D_SUM;
        end
        D_SUM: begin
          d2    <= d2 + {1'b0, prod};
          acc   <= '0;
          idx   <= '0;
          state <= D_MAC;
        end
        D_MAC: begin
          if (idx != MAC_STEPS) begin
            prod    <= prod_next;
            prod_sh <= idx[2:1] + {1'b0, idx[0]};
          end
          if (idx != 3'd0) begin
            acc <= acc + acc_add;
          end
          idx <= idx + 3'd1;
          if (idx == MAC_STEPS) begin
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
            state <= D_ROOT;
          end
        end
        D_ROOT: begin
          rem  <= ge ? (rem_sh - trial) : rem_sh;
          root <= {root[61:0], ge};
          acc  <= {acc[123:0], 2'b00};
          cnt  <= cnt + 6'd1;
          if (cnt == ROOT_LAST) begin
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/wts_div.sv */
// restoring divider, one quotient bit per cycle, 48-bit saturated quotient
// uses wts_pkg
`default_nettype none

module wts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [47:0] quot
);
  import wts_pkg::*;

  typedef enum logic [1:0] {
    V_IDLE = 2'b01,
    V_RUN  = 2'b10
  } vstate_t;

  vstate_t     state;
  logic [63:0] nq;
  logic [16:0] rem, dv;
  logic [5:0]  cnt;
  logic [17:0] sh;
  logic        ge;

  assign sh   = {rem, nq[63]};
  assign ge   = sh >= {1'b0, dv};
  assign quot = (nq[63:48] != 16'd0) ? MAX48 : nq[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= V_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == V_RUN) && (cnt == 6'd63);
      case (state)
        V_IDLE: begin
          if (start) begin
            nq    <= num;
            dv    <= den;
            rem   <= '0;
            cnt   <= '0;
            state <= V_RUN;
          end
        end
        V_RUN: begin
          rem <= ge ? 17'(sh - {1'b0, dv}) : sh[16:0];
          nq  <= {nq[62:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= V_IDLE;
          end
        end
        default: state <= V_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb_waypoint_time_stamper.sv */
// testbench for the waypoint time stamper: drives waypoint paths with random
// gaps and output stalls, predicts every trajectory point and checks each one
// depends on wts_pkg and waypoint_time_stamper
`timescale 1ns / 1ps

module tb_waypoint_time_stamper;
  import wts_pkg::*;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  way_t         in_data;
  logic         out_valid;
  logic         out_stall;
  point_t       out_data;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [39:0]  cfg_data;

  waypoint_time_stamper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // points still owed by the block, oldest first
  point_t pending_points[$];
  int     n_errors;

  // shadow copy of the block's registers and path state
  logic [39:0]        span_reg;
  logic signed [31:0] pose_x_reg;
  logic signed [31:0] pose_y_reg;
  longint             last_way_x, last_way_y, last_emit_x, last_emit_y;
  logic [15:0]        last_speed;
  logic [47:0]        horizon_ns;
  logic [47:0]        last_time_ns;
  logic [1:0]         phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("waypoint_time_stamper: mismatch");
    $finish;
  end

  // distance in nanomillimeters: floor(sqrt((dx^2 + dy^2) * 10^18))
  function automatic logic [63:0] nano_dist(longint dx, longint dy);
    logic [127:0] ux, uy, rem, root, probe;
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    rem = (ux * ux + uy * uy) * 128'd1000000000000000000;
    root = '0;
    probe = 128'd1 << 126;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[63:0];
  endfunction

  // quotient clamped to 48 bits, divide by zero saturates and flags
  function automatic logic [47:0] clamp_div(logic [127:0] num, logic [127:0] den,
                                            inout logic zero);
    logic [127:0] q;
    if (den == 0) begin
      zero = 1'b1;
      return MAX48;
    end
    q = num / den;
    return (q > {80'd0, MAX48}) ? MAX48 : q[47:0];
  endfunction

  function automatic logic [47:0] clamp_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic point_t make_point(longint x, longint y, logic [47:0] t,
                                        logic zero, logic last);
    point_t p;
    p.point_x_mm = x[31:0];
    p.point_y_mm = y[31:0];
    p.point_time_ns = t;
    p.zero_speed = zero;
    p.last_point = last;
    return p;
  endfunction

  // append one expected point at the tail of the queue
  task automatic owe_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  // work out the points caused by one accepted waypoint
  task automatic stamp_waypoint(way_t w);
    longint      wx, wy, px, py, ax, ay;
    logic [47:0] seg, t;
    logic        zero, cut;
    wx = w.way_x_mm;
    wy = w.way_y_mm;
    zero = 1'b0;
    t = '0;
    if (phase == PH_CUT) begin
      // discarding until the path ends
      if (w.path_end) phase = PH_FIRST;
      return;
    end
    if (phase == PH_PATH) begin
      seg = clamp_div(128'(2) * nano_dist(wx - last_way_x, wy - last_way_y),
                      128'(w.way_speed) + 128'(last_speed), zero);
      horizon_ns = clamp_add(horizon_ns, seg);
      cut = horizon_ns >= {8'd0, span_reg};
      zero = 1'b0;
      t = clamp_div(128'(nano_dist(wx - last_emit_x, wy - last_emit_y)),
                    128'(last_speed), zero);
      t = clamp_add(last_time_ns, t);
      owe_point(make_point(wx, wy, t, zero, cut || w.path_end));
      phase = w.path_end ? PH_FIRST : (cut ? PH_CUT : PH_PATH);
    end else begin
      // first waypoint: a pose point comes first when the pose is far away
      px = pose_x_reg;
      py = pose_y_reg;
      ax = (px - wx < 0) ? wx - px : px - wx;
      ay = (py - wy < 0) ? wy - py : py - wy;
      if (ax > NEAR_MM || ay > NEAR_MM) begin
        owe_point(make_point(px, py, '0, 1'b0, 1'b0));
        t = clamp_div(128'(nano_dist(wx - px, wy - py)), 128'(w.way_speed), zero);
      end
      owe_point(make_point(wx, wy, t, zero, w.path_end));
      horizon_ns = '0;
      phase = w.path_end ? PH_FIRST : PH_PATH;
    end
    last_way_x = wx;
    last_emit_x = wx;
    last_way_y = wy;
    last_emit_y = wy;
    last_speed = w.way_speed;
    last_time_ns = t;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // result checker: every accepted point against the oldest expectation
  initial begin
    point_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_points.size() == 0) begin
          report("unexpected point x", out_data.point_x_mm, 0);
        end else begin
          want = pending_points.pop_front();
          if (out_data.point_x_mm !== want.point_x_mm)
            report("point_x_mm", out_data.point_x_mm, want.point_x_mm);
          if (out_data.point_y_mm !== want.point_y_mm)
            report("point_y_mm", out_data.point_y_mm, want.point_y_mm);
          if (out_data.point_time_ns !== want.point_time_ns)
            report("point_time_ns", out_data.point_time_ns, want.point_time_ns);
          if (out_data.zero_speed !== want.zero_speed)
            report("zero_speed", out_data.zero_speed, want.zero_speed);
          if (out_data.last_point !== want.last_point)
            report("last_point", out_data.last_point, want.last_point);
        end
      end
    end
  end

  // receiver stalls: quiet stretches, short bursts and a few long holds
  initial begin
    int hold;
    int pick;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        hold = $urandom_range(1, 40);
        out_stall <= 1'b0;
      end else if (pick < 90) begin
        hold = $urandom_range(1, 3);
        out_stall <= 1'b1;
      end else begin
        hold = $urandom_range(20, 200);
        out_stall <= 1'b1;
      end
      repeat (hold) @(posedge clk);
    end
  end

  // one request on the waypoint channel, then a random gap
  task automatic send_waypoint(way_t w);
    int gap;
    int pick;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    stamp_waypoint(w);
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 5);
    else gap = $urandom_range(20, 300);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic way_t way(int x, int y, int speed, int last);
    way_t w;
    w.way_x_mm = x;
    w.way_y_mm = y;
    w.way_speed = speed[15:0];
    w.path_end = last[0];
    return w;
  endfunction

  // stop sending and wait until every owed point is out and the block is idle
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SPAN:   span_reg = value;
      CFG_POSE_X: pose_x_reg = value[31:0];
      CFG_POSE_Y: pose_y_reg = value[31:0];
      default: ;
    endcase
  endtask

  // pose point on and off around the 100 mm boundary, single point paths and one three point path
  task automatic test_pose_point;
    write_reg(CFG_POSE_X, 40'd1000);
    write_reg(CFG_POSE_Y, 40'hFF_FFFF_FC18);
    send_waypoint(way(1100, -1000, 500, 1));
    send_waypoint(way(1101, -1000, 500, 1));
    send_waypoint(way(1000, -1101, 500, 1));
    send_waypoint(way(900, -900, 0, 0));
    send_waypoint(way(900, -900, 0, 0));
    send_waypoint(way(5000, 2000, 3000, 1));
  endtask

  // field extremes, zero and full speed, zero mean speed
  task automatic test_extremes;
    write_reg(CFG_POSE_X, 40'h00_8000_0000);
    write_reg(CFG_POSE_Y, 40'h00_7FFF_FFFF);
    write_reg(CFG_SPAN, 40'hFF_FFFF_FFFF);
    send_waypoint(way(32'h7FFFFFFF, 32'h80000000, 65535, 0));
    send_waypoint(way(32'h80000000, 32'h7FFFFFFF, 65535, 0));
    send_waypoint(way(32'h80000000, 32'h7FFFFFFF, 1, 0));
    send_waypoint(way(0, 0, 0, 0));
    send_waypoint(way(10, 10, 0, 0));
    send_waypoint(way(20, 20, 40000, 1));
    send_waypoint(way(32'h80000001, 32'h7FFFFFFE, 0, 1));
  endtask

  // cut at the horizon, discard until path end, restart
  task automatic test_cut;
    write_reg(CFG_POSE_X, 40'd0);
    write_reg(CFG_POSE_Y, 40'd0);
    write_reg(CFG_SPAN, 40'd0);
    send_waypoint(way(0, 0, 1000, 0));
    send_waypoint(way(100, 0, 1000, 0));
    send_waypoint(way(200, 0, 1000, 0));
    send_waypoint(way(300, 0, 1000, 1));
    send_waypoint(way(50, 50, 1000, 0));
    write_reg(CFG_SPAN, 40'd250000000);
    send_waypoint(way(60, 50, 1000, 0));
    send_waypoint(way(260, 50, 1000, 0));
    send_waypoint(way(400, 50, 1000, 0));
    send_waypoint(way(500, 50, 1000, 1));
  endtask

  // random paths: mostly well formed, with noise requests mixed in
  task automatic test_random_paths(int n_items, logic [39:0] span,
                                   int pose_x, int pose_y);
    int sent;
    int len;
    int x, y, speed;
    way_t w;
    write_reg(CFG_SPAN, span);
    write_reg(CFG_POSE_X, {{8{pose_x[31]}}, pose_x});
    write_reg(CFG_POSE_Y, {{8{pose_y[31]}}, pose_y});
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        x = pose_x + $urandom_range(0, 200) - 100;
        y = pose_y + $urandom_range(0, 200) - 100;
      end else begin
        x = pose_x + $urandom_range(0, 40000) - 20000;
        y = pose_y + $urandom_range(0, 40000) - 20000;
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          w = way($urandom, $urandom, $urandom_range(0, 65535), $urandom_range(0, 1));
        end else begin
          if (k > 0) begin
            x = x + $urandom_range(0, 10000) - 5000;
            y = y + $urandom_range(0, 10000) - 5000;
          end
          if ($urandom_range(0, 19) == 0) begin
            x = $urandom;
            y = $urandom;
          end
          case ($urandom_range(0, 19))
            0:       speed = 0;
            1:       speed = 65535;
            default: speed = $urandom_range(1, 20000);
          endcase
          w = way(x, y, speed, int'(k == len - 1));
        end
        send_waypoint(w);
        sent++;
        // let the block run dry once mid-stream
        if (sent == n_items / 2) settle();
      end
    end
  endtask

  initial begin
    n_errors = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SPAN;
    cfg_data <= '0;
    span_reg = SPAN_RESET;
    pose_x_reg = '0;
    pose_y_reg = '0;
    last_way_x = 0;
    last_way_y = 0;
    last_emit_x = 0;
    last_emit_y = 0;
    last_speed = '0;
    horizon_ns = '0;
    last_time_ns = '0;
    phase = PH_FIRST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first path runs on the reset configuration
    send_waypoint(way(0, 50, 2000, 0));
    send_waypoint(way(3000, 4000, 2000, 1));
    test_pose_point();
    test_extremes();
    test_cut();
    test_random_paths(300, SPAN_RESET, 0, 0);
    test_random_paths(200, 40'd1500000000, -123456, 654321);
    test_random_paths(200, 40'hFF_FFFF_FFFF, 2000000000, -2000000000);
    test_random_paths(150, {8'($urandom_range(0, 255)), $urandom},
                      $urandom_range(0, 99999), -$urandom_range(0, 99999));

    settle();
    if (n_errors == 0) begin
      $display("waypoint_time_stamper: match");
    end else begin
      $display("waypoint_time_stamper: mismatch");
    end
    $finish;
  end

endmodule
